@@ rtl/tdf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed frame deframer package
// Shared widths, codes, types and decode functions of the deframer.
// ----------------------------------------------------------------------------
package tdf_pkg;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 3;
    localparam int POS_W  = 6;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hAA;

    localparam logic [BYTE_W-1:0] TYPE_ECG   = 8'h06;
    localparam logic [BYTE_W-1:0] TYPE_HR    = 8'h12;
    localparam logic [BYTE_W-1:0] TYPE_RESP  = 8'h03;
    localparam logic [BYTE_W-1:0] TYPE_TEMP  = 8'h05;
    localparam logic [BYTE_W-1:0] TYPE_ACCEL = 8'h02;

    localparam logic [KIND_W-1:0] KIND_ECG   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_HR    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TEMP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ACCEL = 3'd4;

    // Position of the type byte, the first byte that produces a result.
    localparam logic [POS_W-1:0] POS_TYPE = 6'd2;

    typedef enum logic [1:0] {
        ST_HUNT_FIRST,
        ST_HUNT_SECOND,
        ST_TYPE,
        ST_FRAME
    } t_state;

    typedef struct packed {
        logic              known;
        logic [KIND_W-1:0] kind;
    } t_type_dec;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [POS_W-1:0]  index;
        logic              last;
    } t_result;

    function automatic t_type_dec decode_type(input logic [BYTE_W-1:0] t);
        t_type_dec d;
        d.known = 1'b1;
        case (t)
            TYPE_ECG:   d.kind = KIND_ECG;
            TYPE_HR:    d.kind = KIND_HR;
            TYPE_RESP:  d.kind = KIND_RESP;
            TYPE_TEMP:  d.kind = KIND_TEMP;
            TYPE_ACCEL: d.kind = KIND_ACCEL;
            default: begin
                d.known = 1'b0;
                d.kind  = KIND_ECG;
            end
        endcase
        return d;
    endfunction

    // Final byte position of a frame: total length minus one.
    function automatic logic [POS_W-1:0] final_pos(input logic [KIND_W-1:0] kind);
        logic [POS_W-1:0] p;
        case (kind)
            KIND_ECG:  p = 6'd33;
            KIND_HR:   p = 6'd9;
            KIND_RESP: p = 6'd5;
            KIND_TEMP: p = 6'd13;
            default:   p = 6'd4;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

@@ rtl/tdf_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed frame deframer parser
// Header hunt and frame tracking state; builds the result word for a byte.
// ----------------------------------------------------------------------------
module tdf_parser (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_advance,
    input  wire logic [tdf_pkg::BYTE_W-1:0] i_byte,
    output tdf_pkg::t_result               o_res,
    output logic                           o_res_valid
);

    tdf_pkg::t_state                r_state, n_state;
    logic [tdf_pkg::KIND_W-1:0]     r_kind, n_kind;
    logic [tdf_pkg::POS_W-1:0]      r_pos, n_pos;

    tdf_pkg::t_type_dec             dec;
    logic                           at_last;

    assign dec     = tdf_pkg::decode_type(i_byte);
    assign at_last = (r_pos >= tdf_pkg::final_pos(r_kind));

    // Next state.
    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_pos   = r_pos;
        if (i_advance) begin
            case (r_state)
                tdf_pkg::ST_HUNT_FIRST: begin
                    if (i_byte == tdf_pkg::HDR_BYTE) n_state = tdf_pkg::ST_HUNT_SECOND;
                end
                tdf_pkg::ST_HUNT_SECOND: begin
                    n_state = (i_byte == tdf_pkg::HDR_BYTE) ? tdf_pkg::ST_TYPE
                                                             : tdf_pkg::ST_HUNT_FIRST;
                end
                tdf_pkg::ST_TYPE: begin
                    if (dec.known) begin
                        n_state = tdf_pkg::ST_FRAME;
                        n_kind  = dec.kind;
                        n_pos   = tdf_pkg::POS_TYPE + 6'd1;
                    end else begin
                        n_state = tdf_pkg::ST_HUNT_FIRST;
                    end
                end
                tdf_pkg::ST_FRAME: begin
                    if (at_last) begin
                        n_state = tdf_pkg::ST_HUNT_FIRST;
                        n_pos   = tdf_pkg::POS_TYPE;
                    end else begin
                        n_pos = r_pos + 6'd1;
                    end
                end
                default: n_state = tdf_pkg::ST_HUNT_FIRST;
            endcase
        end
    end

    // Result for the byte currently presented.
    always_comb begin
        o_res.data  = i_byte;
        o_res_valid = 1'b0;
        o_res.kind  = r_kind;
        o_res.index = r_pos;
        o_res.last  = 1'b0;
        case (r_state)
            tdf_pkg::ST_TYPE: begin
                o_res_valid = dec.known;
                o_res.kind  = dec.kind;
                o_res.index = tdf_pkg::POS_TYPE;
            end
            tdf_pkg::ST_FRAME: begin
                o_res_valid = 1'b1;
                o_res.last  = at_last;
            end
            default: o_res_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdf_pkg::ST_HUNT_FIRST;
            r_kind  <= tdf_pkg::KIND_ECG;
            r_pos   <= tdf_pkg::POS_TYPE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_pos   <= n_pos;
        end
    end

endmodule
`default_nettype wire

@@ rtl/tdf_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed frame deframer output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module tdf_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire tdf_pkg::t_result  i_res,
    input  wire logic              i_stall,
    output logic                   o_busy,
    output logic                   o_valid,
    output tdf_pkg::t_result       o_res
);

    logic             r_valid;
    tdf_pkg::t_result r_res;

    // A held word blocks a new load only while downstream stalls.
    assign o_busy  = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

@@ rtl/typed_frame_deframer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed frame deframer core
// Finds 0xAA 0xAA <type> frames in a byte stream and emits tagged frame bytes.
// ----------------------------------------------------------------------------
// One byte is accepted per clock when downstream keeps up. A byte is captured
// in an input register, decoded against the frame state, and its result word
// (if any) lands in the output register. Header bytes and rejected bytes
// produce no word. The only backpressure path is a full, stalled output
// register holding up the input register.
module typed_frame_deframer_core (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [tdf_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                            o_stall,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [tdf_pkg::KIND_W-1:0]      o_frame_kind,
    output logic [tdf_pkg::BYTE_W-1:0]      o_data_byte,
    output logic [tdf_pkg::POS_W-1:0]       o_byte_index,
    output logic                            o_last_of_frame
);

    logic                       r_in_valid;
    logic [tdf_pkg::BYTE_W-1:0] r_in_byte;

    tdf_pkg::t_result           res;
    logic                       res_valid;
    logic                       out_busy;
    logic                       advance;
    tdf_pkg::t_result           out_res;

    // A byte without a result never waits on the output register.
    assign advance = r_in_valid && !(res_valid && out_busy);
    assign o_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    tdf_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_byte      (r_in_byte),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    tdf_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_busy  (out_busy),
        .o_valid (o_valid),
        .o_res   (out_res)
    );

    assign o_frame_kind    = out_res.kind;
    assign o_data_byte     = out_res.data;
    assign o_byte_index    = out_res.index;
    assign o_last_of_frame = out_res.last;

endmodule
`default_nettype wire

@@ rtl/tdf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Typed frame deframer checker
// Port-level assertions on the result words, bound to the core.
// ----------------------------------------------------------------------------
module tdf_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       o_valid,
    input wire logic                       i_stall,
    input wire logic [tdf_pkg::KIND_W-1:0] o_frame_kind,
    input wire logic [tdf_pkg::BYTE_W-1:0] o_data_byte,
    input wire logic [tdf_pkg::POS_W-1:0]  o_byte_index,
    input wire logic                       o_last_of_frame
);

    logic [tdf_pkg::POS_W-1:0] fin;
    assign fin = tdf_pkg::final_pos(o_frame_kind);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data_byte) && $stable(o_byte_index)
            && $stable(o_frame_kind) && $stable(o_last_of_frame))
        else $error("stalled result word changed");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_byte_index >= tdf_pkg::POS_TYPE && o_byte_index <= fin
            && o_frame_kind <= tdf_pkg::KIND_ACCEL)
        else $error("byte index outside its frame");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last_of_frame == (o_byte_index == fin))
        else $error("last flag does not match final position");

    a_type_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_byte_index == tdf_pkg::POS_TYPE |-> !o_last_of_frame)
        else $error("type byte flagged as last");

endmodule

bind typed_frame_deframer_core tdf_checker u_tdf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_frame_kind    (o_frame_kind),
    .o_data_byte     (o_data_byte),
    .o_byte_index    (o_byte_index),
    .o_last_of_frame (o_last_of_frame)
);
`default_nettype wire
